// ===== hw/rtl/kslp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kslp_pkg;

  localparam int unsigned PIN_W   = 4;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned KEY_W   = 8;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned CFG_DW  = 32;
  localparam int unsigned CFG_AW  = 3;

  localparam logic [COUNT_W-1:0] SHORT_TICKS_RST = 16'd5;
  localparam logic [COUNT_W-1:0] LONG_TICKS_RST  = 16'd80;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = 16'hFFFF;

  // register index, taken from paddr[2]
  localparam logic REG_SHORT_TICKS = 1'b0;
  localparam logic REG_LONG_TICKS  = 1'b1;

  // key masks of interest
  localparam logic [PIN_W-1:0] KEY_MODE  = 4'h2;
  localparam logic [PIN_W-1:0] KEY_CLEAN = 4'h4;

  // work modes
  localparam logic [MODE_W-1:0] MODE_SMART      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CARPET     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SELF_CLEAN = 2'd3;

  typedef struct packed {
    logic [COUNT_W-1:0] short_ticks;
    logic [COUNT_W-1:0] long_ticks;
  } cfg_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key_code;
    logic [MODE_W-1:0] op_mode;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/kslp_press_det.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Press timing and mode selection for one scan tick. State advances on step.
module kslp_press_det (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          step,
  input  wire logic [kslp_pkg::PIN_W-1:0]    pin_levels,
  input  wire logic                          upright,
  input  wire kslp_pkg::cfg_t                cfg,
  output kslp_pkg::result_t                  result
);
  import kslp_pkg::*;

  logic [PIN_W-1:0]   previous_mask, previous_mask_next;
  logic [COUNT_W-1:0] hold_count, hold_count_next;
  logic               long_reported, long_reported_next;
  logic [PIN_W-1:0]   pending_short, pending_short_next;
  logic [MODE_W-1:0]  current_mode, current_mode_next;

  logic [PIN_W-1:0]   mask;
  logic [COUNT_W-1:0] count_inc;
  logic [KEY_W-1:0]   key;

  assign mask      = ~pin_levels;
  assign count_inc = (hold_count != COUNT_MAX) ? hold_count + 16'd1 : hold_count;

  always_comb begin
    key                = '0;
    hold_count_next    = hold_count;
    long_reported_next = long_reported;
    pending_short_next = pending_short;
    previous_mask_next = mask;
    if (mask != '0) begin
      if (!long_reported) begin
        if (mask == previous_mask) begin
          hold_count_next = count_inc;
          if (count_inc >= cfg.short_ticks) begin
            pending_short_next = mask;
          end
          if (count_inc >= cfg.long_ticks) begin
            key                = {1'b1, 3'b000, mask};
            pending_short_next = '0;
            long_reported_next = 1'b1;
          end
        end else begin
          hold_count_next = '0;
        end
      end
    end else begin
      if (pending_short != '0) begin
        key                = {4'h0, pending_short};
        pending_short_next = '0;
      end
      long_reported_next = 1'b0;
      hold_count_next    = '0;
    end
  end

  // mode key (short or long) toggles smart/carpet when not upright;
  // short clean key while upright enters self-clean for good
  always_comb begin
    current_mode_next = current_mode;
    if (key[KEY_W-2:0] == {3'b000, KEY_MODE} && !upright &&
        current_mode != MODE_SELF_CLEAN) begin
      current_mode_next = (current_mode == MODE_SMART) ? MODE_CARPET : MODE_SMART;
    end
    if (key == {4'h0, KEY_CLEAN} && upright) begin
      current_mode_next = MODE_SELF_CLEAN;
    end
  end

  assign result.key_code = key;
  assign result.op_mode  = current_mode_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_mask <= '0;
      hold_count    <= '0;
      long_reported <= 1'b0;
      pending_short <= '0;
      current_mode  <= MODE_SMART;
    end else if (step) begin
      previous_mask <= previous_mask_next;
      hold_count    <= hold_count_next;
      long_reported <= long_reported_next;
      pending_short <= pending_short_next;
      current_mode  <= current_mode_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/key_short_long_press_mode_select_core.sv =====
// Each accepted item is held in the input register; its result is then held in the result
// register until it is taken.
// Throughput: one item per cycle; the input register takes a new item whenever it is
// empty or its item moves on, which needs the result register free or being emptied.
// Every item gives exactly one result item.
// Reset (rst, synchronous, active high) empties both registers, clears the press
// state, sets smart mode and loads thresholds 5 and 80 ticks.
`timescale 1ns / 1ps
`default_nettype none

module key_short_long_press_mode_select_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // slave side
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [7:0]                    s_tdata,  // [3:0] pin_levels, [4] upright, rest 0
  // master side
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [15:0]                        m_tdata,  // [7:0] key_code, [9:8] op_mode, rest 0
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [kslp_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [kslp_pkg::CFG_DW-1:0]   pwdata,
  output logic [kslp_pkg::CFG_DW-1:0]        prdata,
  output logic                               pready
);
  import kslp_pkg::*;

  cfg_t cfg;

  // input register
  logic             in_valid;
  logic [PIN_W-1:0] in_pins;
  logic             in_upright;

  // result register
  logic [KEY_W-1:0]  out_key;
  logic [MODE_W-1:0] out_mode;

  logic    advance;
  result_t result;

  // ---- configuration port: writes land on the access phase
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_ticks <= SHORT_TICKS_RST;
      cfg.long_ticks  <= LONG_TICKS_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_SHORT_TICKS: cfg.short_ticks <= pwdata[COUNT_W-1:0];
        REG_LONG_TICKS:  cfg.long_ticks  <= pwdata[COUNT_W-1:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SHORT_TICKS: prdata = {{(CFG_DW-COUNT_W){1'b0}}, cfg.short_ticks};
      REG_LONG_TICKS:  prdata = {{(CFG_DW-COUNT_W){1'b0}}, cfg.long_ticks};
      default:         prdata = '0;
    endcase
  end

  // ---- flow control: the held item moves on when the result register frees up
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_pins    <= s_tdata[PIN_W-1:0];
      in_upright <= s_tdata[PIN_W];
    end
  end

  // ---- press detection and mode state, stepped once per item
  kslp_press_det u_det (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .pin_levels (in_pins),
    .upright    (in_upright),
    .cfg        (cfg),
    .result     (result)
  );

  // ---- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_key  <= result.key_code;
      out_mode <= result.op_mode;
    end
  end

  assign m_tdata = {6'b000000, out_mode, out_key};

endmodule

`default_nettype wire

// ===== hw/rtl/kslp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kslp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata
);

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // mode 2 is never reachable from reset
  a_no_mode2: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[9:8] != 2'd2)
    else $error("work mode 2 reported");

  // key code carries only the mask and the long flag; padding stays zero
  a_key_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[6:4] == 3'b000) && (m_tdata[15:10] == 6'b000000))
    else $error("stray bits in result");

  // a long report always has a nonzero mask
  a_long_mask: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[7]) |-> (m_tdata[3:0] != 4'h0))
    else $error("long press with empty mask");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind key_short_long_press_mode_select_core kslp_checker u_kslp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
